@@ rtl/core/tlbl_pkg.sv @@
// Package for the fully associative TLB with LRU replacement.
// Holds sizes, operation and state codes, and the structs passed between modules.
// No dependencies.
package tlbl_pkg;

	localparam int ENTRIES     = 16;
	localparam int PAGE_WIDTH  = 8;
	localparam int FRAME_WIDTH = 8;
	localparam int IDX_W       = $clog2(ENTRIES);
	localparam int AGE_W       = IDX_W;
	localparam int CNT_W       = $clog2(ENTRIES + 1);
	localparam int CTR_W       = 32;

	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [AGE_W-1:0]       age_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [PAGE_WIDTH-1:0]  page_t;
	typedef logic [FRAME_WIDTH-1:0] frame_t;
	typedef logic [CTR_W-1:0]       ctr_t;

	typedef enum logic [1:0] {
		FN_QUERY  = 2'd0,
		FN_INSERT = 2'd1,
		FN_REMOVE = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic   valid;
		page_t  page;
		frame_t frame;
		age_t   age;
	} ent_t;

	typedef struct packed {
		logic   en;
		logic   clear;
		logic   touch;
		logic   drop;
		logic   wr_page;
		logic   wr_frame;
		idx_t   idx;
		age_t   old_age;
		page_t  page;
		frame_t frame;
	} upd_t;

	typedef struct packed {
		logic   found;
		idx_t   hit_idx;
		frame_t hit_frame;
		age_t   hit_age;
		logic   free_found;
		idx_t   free_idx;
		idx_t   lru_idx;
		age_t   lru_age;
		cnt_t   count;
	} scan_res_t;

endpackage

@@ rtl/core/tlbl_store.sv @@
// Entry storage: page, frame, valid and recency rank of every entry.
// One read port at the scan index, one update per transfer.
// Depends on tlbl_pkg.
module tlbl_store import tlbl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  idx_t                rd_idx,
	output ent_t                rd,
	input  upd_t                upd,
	output logic [ENTRIES-1:0]  valid_vec
);

	logic [ENTRIES-1:0] valid_q;
	age_t               age_q   [ENTRIES];
	page_t              page_q  [ENTRIES];
	frame_t             frame_q [ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			age_q   <= '{default: '0};
		end else if (upd.en) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (upd.clear) begin
					valid_q[i] <= 1'b0;
					age_q[i]   <= '0;
				end else if (IDX_W'(i) == upd.idx) begin
					if (upd.touch) begin
						valid_q[i] <= 1'b1;
						age_q[i]   <= '0;
					end else if (upd.drop) begin
						valid_q[i] <= 1'b0;
						age_q[i]   <= '0;
					end
				end else if (valid_q[i]) begin
					if (upd.touch && age_q[i] < upd.old_age) begin
						age_q[i] <= AGE_W'(age_q[i] + 1'b1);
					end else if (upd.drop && age_q[i] > upd.old_age) begin
						age_q[i] <= AGE_W'(age_q[i] - 1'b1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && upd.wr_page) begin
			page_q[upd.idx] <= upd.page;
		end
		if (upd.en && upd.wr_frame) begin
			frame_q[upd.idx] <= upd.frame;
		end
	end

	assign rd.valid  = valid_q[rd_idx];
	assign rd.page   = page_q[rd_idx];
	assign rd.frame  = frame_q[rd_idx];
	assign rd.age    = age_q[rd_idx];
	assign valid_vec = valid_q;

endmodule

@@ rtl/core/tlbl_scan.sv @@
// Shared scan unit: one page comparator and one age comparator, one entry per cycle.
// Collects match, first free slot, oldest entry and valid count.
// Depends on tlbl_pkg.
module tlbl_scan import tlbl_pkg::*; (
	input  logic      clk,
	input  logic      step,
	input  logic      first,
	input  idx_t      idx,
	input  ent_t      ent,
	input  page_t     key,
	output scan_res_t res
);

	scan_res_t res_q;
	logic      match;
	logic      older;

	assign match = ent.valid && (ent.page == key);
	assign older = ent.age > res_q.lru_age;

	always_ff @(posedge clk) begin
		if (step) begin
			if (first) begin
				res_q.found      <= match;
				res_q.hit_idx    <= idx;
				res_q.hit_frame  <= ent.frame;
				res_q.hit_age    <= ent.age;
				res_q.free_found <= !ent.valid;
				res_q.free_idx   <= idx;
				res_q.lru_idx    <= idx;
				res_q.lru_age    <= ent.age;
				res_q.count      <= CNT_W'(ent.valid);
			end else begin
				if (match && !res_q.found) begin
					res_q.found     <= 1'b1;
					res_q.hit_idx   <= idx;
					res_q.hit_frame <= ent.frame;
					res_q.hit_age   <= ent.age;
				end
				if (!ent.valid && !res_q.free_found) begin
					res_q.free_found <= 1'b1;
					res_q.free_idx   <= idx;
				end
				if (older) begin
					res_q.lru_idx <= idx;
					res_q.lru_age <= ent.age;
				end
				res_q.count <= CNT_W'(res_q.count + CNT_W'(ent.valid));
			end
		end
	end

	assign res = res_q;

endmodule

@@ rtl/core/tlb_lru_fully_associative.sv @@
// Fully associative TLB, 16 entries, LRU replacement; top level with sequencer.
// An input transfer is accepted in idle; the scan then visits each entry in turn through the
// shared comparator, and apply updates the store and registers the result. No new item is
// accepted until apply. Clear skips the scan. A stalled result holds the sequencer in apply.
// Reset empties the buffer and zeroes the counters.
// Depends on tlbl_pkg, tlbl_store, tlbl_scan.
module tlb_lru_fully_associative import tlbl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // page[7:0], frame[15:8]
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // frame_out[7:0], hits_total[39:8],
	                                   // misses_total[71:40], occupancy[76:72],
	                                   // full_res[77], zero[79:78]
	output logic        m_axis_tuser   // hit
);

	state_t             state_q, state_d;
	func_t              func_q;
	page_t              page_q;
	frame_t             frame_q;
	idx_t               idx_q;
	ctr_t               hits_q, misses_q;
	logic               out_valid_q;
	logic               out_hit_q;
	logic [7:0]         out_frame_q;
	ctr_t               out_hits_q, out_misses_q;
	cnt_t               out_occ_q;
	logic               out_full_q;

	ent_t               ent;
	upd_t               upd;
	scan_res_t          res;
	logic [ENTRIES-1:0] valid_vec;
	logic               in_xfer, out_free, apply, scan_step, last_idx;
	logic               res_hit;
	logic [7:0]         res_frame;
	cnt_t               occ;

	assign in_xfer   = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign apply     = (state_q == ST_APPLY) && out_free;
	assign scan_step = (state_q == ST_SCAN);
	assign last_idx  = (idx_q == IDX_W'(ENTRIES - 1));

	tlbl_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_idx    (idx_q),
		.rd        (ent),
		.upd       (upd),
		.valid_vec (valid_vec)
	);

	tlbl_scan u_scan (
		.clk   (clk),
		.step  (scan_step),
		.first (idx_q == '0),
		.idx   (idx_q),
		.ent   (ent),
		.key   (page_q),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = (func_t'(s_axis_tuser) == FN_CLEAR) ? ST_APPLY : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_idx) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q  <= func_t'(s_axis_tuser);
			page_q  <= page_t'(s_axis_tdata[7:0]);
			frame_q <= frame_t'(s_axis_tdata[15:8]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (in_xfer) begin
			idx_q <= '0;
		end else if (scan_step && !last_idx) begin
			idx_q <= IDX_W'(idx_q + 1'b1);
		end
	end

	always_comb begin
		upd          = '0;
		upd.en       = apply;
		upd.page     = page_q;
		upd.frame    = frame_q;
		upd.idx      = res.hit_idx;
		upd.old_age  = res.hit_age;
		res_hit      = 1'b0;
		res_frame    = '0;
		occ          = res.count;
		case (func_q)
			FN_QUERY: begin
				if (res.found) begin
					upd.touch = 1'b1;
					res_hit   = 1'b1;
					res_frame = 8'(res.hit_frame);
				end
			end
			FN_INSERT: begin
				upd.touch    = 1'b1;
				upd.wr_frame = 1'b1;
				if (!res.found) begin
					upd.wr_page = 1'b1;
					if (res.free_found) begin
						upd.idx     = res.free_idx;
						upd.old_age = AGE_W'(res.count);
						occ         = CNT_W'(res.count + 1'b1);
					end else begin
						upd.idx     = res.lru_idx;
						upd.old_age = res.lru_age;
					end
				end
			end
			FN_REMOVE: begin
				if (res.found) begin
					upd.drop = 1'b1;
					res_hit  = 1'b1;
					occ      = CNT_W'(res.count - 1'b1);
				end
			end
			FN_CLEAR: begin
				upd.clear = 1'b1;
				occ       = '0;
			end
			default: begin
				upd.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			misses_q <= '0;
		end else if (apply) begin
			if (func_q == FN_CLEAR) begin
				hits_q   <= '0;
				misses_q <= '0;
			end else if (func_q == FN_QUERY) begin
				if (res.found && hits_q != '1) begin
					hits_q <= CTR_W'(hits_q + 1'b1);
				end
				if (!res.found && misses_q != '1) begin
					misses_q <= CTR_W'(misses_q + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			out_hit_q    <= res_hit;
			out_frame_q  <= res_frame;
			out_occ_q    <= occ;
			out_full_q   <= (occ == CNT_W'(ENTRIES));
			if (func_q == FN_CLEAR) begin
				out_hits_q   <= '0;
				out_misses_q <= '0;
			end else if (func_q == FN_QUERY && res.found && hits_q != '1) begin
				out_hits_q   <= CTR_W'(hits_q + 1'b1);
				out_misses_q <= misses_q;
			end else if (func_q == FN_QUERY && !res.found && misses_q != '1) begin
				out_hits_q   <= hits_q;
				out_misses_q <= CTR_W'(misses_q + 1'b1);
			end else begin
				out_hits_q   <= hits_q;
				out_misses_q <= misses_q;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_hit_q;
	assign m_axis_tdata  = {2'b00, out_full_q, 5'(out_occ_q), out_misses_q, out_hits_q,
		out_frame_q};

	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		apply |=> ($countones(valid_vec) == int'(out_occ_q)))
		else $error("occupancy disagrees with valid bits");

	a_hits_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		(apply && func_q != FN_CLEAR) |=> (hits_q >= $past(hits_q)))
		else $error("hit counter decreased without clear");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !s_axis_tready)
		else $error("input taken during scan");

endmodule

@@ sim/tb.sv @@
// Testbench for tlb_lru_fully_associative: directed rows, then random lookups, fills,
// removes and clears under several idle/stall mixes, checked against an LRU predictor.
// Depends on tlbl_pkg and the RTL of the TLB.
module tb;
	import tlbl_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int RAND_ITEMS   = 800;

	typedef struct packed {
		logic   hit;
		frame_t frame_out;
		ctr_t   hits;
		ctr_t   misses;
		cnt_t   occ;
		logic   full;
	} xlate_res_t;

	typedef struct {
		func_t      op;
		page_t      pg;
		frame_t     fr;
		bit         typed;
		xlate_res_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = FN_QUERY;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic        m_axis_tuser;

	page_t  tlb_page[ENTRIES];
	frame_t tlb_frame[ENTRIES];
	bit     tlb_valid[ENTRIES];
	int     tlb_age[ENTRIES];
	ctr_t   hit_ctr;
	ctr_t   miss_ctr;

	xlate_res_t pending_results[$];
	dir_row_t   dir_rows[$];
	int         errors = 0;
	int         cycle_cnt = 0;
	int         stall_pct = 0;
	int         pressure_req = 0;

	tlb_lru_fully_associative u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int find_page(page_t pg);
		for (int i = 0; i < ENTRIES; i++)
			if (tlb_valid[i] && tlb_page[i] == pg)
				return i;
		return -1;
	endfunction

	function automatic int valid_count();
		int n = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (tlb_valid[i])
				n++;
		return n;
	endfunction

	// make entry idx most recent; younger entries age by one
	function automatic void promote(int idx);
		int old = tlb_age[idx];
		for (int i = 0; i < ENTRIES; i++)
			if (tlb_valid[i] && i != idx && tlb_age[i] < old)
				tlb_age[i]++;
		tlb_age[idx] = 0;
	endfunction

	function automatic void flush_tlb();
		for (int i = 0; i < ENTRIES; i++) begin
			tlb_valid[i] = 1'b0;
			tlb_age[i] = 0;
		end
		hit_ctr = '0;
		miss_ctr = '0;
	endfunction

	function automatic xlate_res_t predict_translation(func_t op, page_t pg, frame_t fr);
		xlate_res_t res;
		int idx;
		int old;
		int n;
		res = '0;
		case (op)
			FN_QUERY: begin
				idx = find_page(pg);
				if (idx >= 0) begin
					res.hit = 1'b1;
					res.frame_out = tlb_frame[idx];
					promote(idx);
					if (hit_ctr != '1)
						hit_ctr++;
				end else if (miss_ctr != '1) begin
					miss_ctr++;
				end
			end
			FN_INSERT: begin
				idx = find_page(pg);
				if (idx < 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (!tlb_valid[i] && idx < 0)
							idx = i;
					if (idx >= 0) begin
						tlb_age[idx] = valid_count();
						tlb_valid[idx] = 1'b1;
					end else begin
						idx = 0;
						for (int i = 1; i < ENTRIES; i++)
							if (tlb_age[i] > tlb_age[idx])
								idx = i;
					end
					tlb_page[idx] = pg;
				end
				tlb_frame[idx] = fr;
				promote(idx);
			end
			FN_REMOVE: begin
				idx = find_page(pg);
				if (idx >= 0) begin
					old = tlb_age[idx];
					tlb_valid[idx] = 1'b0;
					tlb_age[idx] = 0;
					for (int i = 0; i < ENTRIES; i++)
						if (tlb_valid[i] && tlb_age[i] > old)
							tlb_age[i]--;
					res.hit = 1'b1;
				end
			end
			default: begin
				flush_tlb();
			end
		endcase
		n = valid_count();
		res.hits = hit_ctr;
		res.misses = miss_ctr;
		res.occ = cnt_t'(n);
		res.full = (n == ENTRIES);
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, field, got, want);
		errors++;
	endtask

	task automatic send_item(input func_t op, input page_t pg, input frame_t fr,
		input int idle_pct, input bit typed, input xlate_res_t want);
		xlate_res_t pred;
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {fr, pg};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pred = predict_translation(op, pg, fr);
		pending_results.push_back(typed ? want : pred);
	endtask

	function automatic xlate_res_t mk_res(logic hit, frame_t fo, ctr_t h, ctr_t m, int occ);
		xlate_res_t r;
		r.hit = hit;
		r.frame_out = fo;
		r.hits = h;
		r.misses = m;
		r.occ = cnt_t'(occ);
		r.full = (occ == ENTRIES);
		return r;
	endfunction

	function automatic void add_row(func_t op, page_t pg, frame_t fr, bit typed,
		xlate_res_t want);
		dir_row_t row;
		row.op = op;
		row.pg = pg;
		row.fr = fr;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	function automatic void load_directed();
		add_row(FN_QUERY, 8'h5A, 8'hFF, 1'b1, mk_res(1'b0, '0, '0, 32'd1, 0));
		add_row(FN_REMOVE, 8'h5A, 8'h00, 1'b1, mk_res(1'b0, '0, '0, 32'd1, 0));
		for (int i = 0; i < ENTRIES; i++)
			add_row(FN_INSERT, page_t'(i * 17), frame_t'(255 - i * 17), 1'b0, '0);
		add_row(FN_QUERY, 8'h00, 8'h81, 1'b0, '0);
		// full: evicts the least recent entry
		add_row(FN_INSERT, 8'hA5, 8'h3C, 1'b0, '0);
		add_row(FN_QUERY, 8'h11, 8'h00, 1'b0, '0);
		// present page: update frame in place
		add_row(FN_INSERT, 8'hFF, 8'hC3, 1'b0, '0);
		add_row(FN_QUERY, 8'hFF, 8'h7E, 1'b0, '0);
		add_row(FN_REMOVE, 8'h33, 8'hFF, 1'b0, '0);
		add_row(FN_CLEAR, 8'hFF, 8'hFF, 1'b1, '0);
		add_row(FN_QUERY, 8'hFF, 8'h00, 1'b1, mk_res(1'b0, '0, '0, 32'd1, 0));
	endfunction

	// result side: check transfers, then pick tready for the next edge
	initial begin
		xlate_res_t got;
		xlate_res_t want;
		int pressure_ack;
		int hold_left;
		pressure_ack = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.hit = m_axis_tuser;
				got.frame_out = m_axis_tdata[7:0];
				got.hits = m_axis_tdata[39:8];
				got.misses = m_axis_tdata[71:40];
				got.occ = m_axis_tdata[76:72];
				got.full = m_axis_tdata[77];
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
				end else begin
					want = pending_results.pop_front();
					if (got.hit != want.hit)
						report_mismatch("hit", 32'(got.hit), 32'(want.hit));
					if (got.frame_out != want.frame_out)
						report_mismatch("frame_out", 32'(got.frame_out),
							32'(want.frame_out));
					if (got.hits != want.hits)
						report_mismatch("hits_total", got.hits, want.hits);
					if (got.misses != want.misses)
						report_mismatch("misses_total", got.misses, want.misses);
					if (got.occ != want.occ)
						report_mismatch("occupancy", 32'(got.occ), 32'(want.occ));
					if (got.full != want.full)
						report_mismatch("full_res", 32'(got.full), 32'(want.full));
				end
			end
			if (pressure_req != pressure_ack) begin
				pressure_ack = pressure_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int send_pct;
		int r;
		func_t op;
		page_t pg;
		dir_row_t row;
		for (int i = 0; i < ENTRIES; i++) begin
			tlb_page[i] = '0;
			tlb_frame[i] = '0;
		end
		flush_tlb();
		load_directed();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_item(row.op, row.pg, row.fr, 0, row.typed, row.want);
		end
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_pct = 0;  stall_pct <= 0;  pressure_req <= pressure_req + 1; end
				1: begin send_pct = 46; stall_pct <= 0;  end
				2: begin send_pct = 0;  stall_pct <= 46; end
				default: begin send_pct = 6; stall_pct <= 6; end
			endcase
			for (int k = 0; k < RAND_ITEMS / 4; k++) begin
				r = $urandom_range(99);
				if (r < 44)
					op = FN_QUERY;
				else if (r < 84)
					op = FN_INSERT;
				else if (r < 99)
					op = FN_REMOVE;
				else
					op = FN_CLEAR;
				// mostly a pool a bit larger than the buffer, so hits and evictions occur
				if ($urandom_range(99) < 85)
					pg = page_t'($urandom_range(0, 23) * 11);
				else
					pg = page_t'($urandom_range(0, 255));
				send_item(op, pg, frame_t'($urandom_range(0, 255)), send_pct, 1'b0, '0);
			end
		end
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
